/* rtl/core/hrfs_pkg.sv */
`default_nettype none

package hrfs_pkg;

  // parse phase of the request text
  typedef enum logic [3:0] {
    PH_METHOD  = 4'd0,
    PH_URI     = 4'd1,
    PH_VERSION = 4'd2,
    PH_NAME    = 4'd3,
    PH_VALUE   = 4'd4,
    PH_SKIP    = 4'd5,
    PH_BODY    = 4'd6
  } phase_e;

  localparam int unsigned KIND_W = 3;

  localparam logic [KIND_W-1:0] KIND_METHOD = 3'd0;
  localparam logic [KIND_W-1:0] KIND_URI    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_NAME   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_VALUE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_BODY   = 3'd4;

  localparam logic [7:0] CHAR_SP = 8'h20;
  localparam logic [7:0] CHAR_LF = 8'h0a;
  localparam logic [7:0] CHAR_CR = 8'h0d;

  // result queue
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0]        data;
    logic              byte_valid;
    logic [KIND_W-1:0] kind;
    logic              first;
    logic              done;
    logic              req_valid;
  } result_t;

  // results produced by one input word, in order
  typedef struct packed {
    result_t    r0;
    result_t    r1;
    logic [1:0] cnt;
  } step_out_t;

endpackage

`default_nettype wire

/* rtl/core/http_request_field_splitter.sv */
// HTTP request field splitter.
// s_axis: one request byte per word; tdata is the byte, tlast marks the
// final byte of the request.
// m_axis: tagged words. tdata carries the field byte; tuser carries
// byte_valid, field_kind (0 method, 1 uri, 2 header name, 3 header value,
// 4 body), field_first and request_valid; tlast marks the done word of a
// request, whose request_valid says both request-line spaces were seen.
// A field byte leaves the splitter once the next byte has been taken: it is
// written into the result queue at the handshake of that next byte; the final
// byte of a request may give two words, written into the queue together.
// Throughput: one byte per cycle while s_axis_tready is high; the parse state
// is updated at each byte handshake. A four-word result queue sits between the
// parser and m_axis, and s_axis_tready stays high while at least two queue
// slots are free, so with a stalled receiver s_axis stops once three words wait
// (bytes that give no word are still taken until then) and no word is dropped.
// Reset clears the parse state to the start of a method and empties the
// queue; the block is ready straight out of reset.
`default_nettype none

module http_request_field_splitter
  import hrfs_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] byte_in
  input  wire logic       s_axis_tlast,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
  output logic [5:0]      m_axis_tuser,   // [0] byte_valid, [3:1] field_kind,
                                          // [4] field_first, [5] request_valid
  output logic            m_axis_tlast
);

  logic      in_fire;
  logic      has_room;
  step_out_t step;
  result_t   head;
  logic [1:0] push_cnt;

  assign s_axis_tready = has_room;
  assign in_fire       = s_axis_tvalid && has_room;
  assign push_cnt      = in_fire ? step.cnt : 2'd0;

  hrfs_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (in_fire),
    .byte_i (s_axis_tdata),
    .last_i (s_axis_tlast),
    .step_o (step)
  );

  hrfs_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .push0_i    (step.r0),
    .push1_i    (step.r1),
    .has_room_o (has_room),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .head_o     (head)
  );

  assign m_axis_tdata = head.data;
  assign m_axis_tuser = {head.req_valid, head.first, head.kind, head.byte_valid};
  assign m_axis_tlast = head.done;

endmodule

`default_nettype wire

/* rtl/core/hrfs_parser.sv */
`default_nettype none

module hrfs_parser
  import hrfs_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       fire_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       last_i,
  output step_out_t       step_o
);

  phase_e            phase_q, phase_d;
  logic              start_q, start_d;
  logic [7:0]        hold_byte_q, hold_byte_d;
  logic [KIND_W-1:0] hold_kind_q, hold_kind_d;
  logic              hold_first_q, hold_first_d;
  logic              hold_present_q, hold_present_d;

  phase_e            eff_phase;
  logic              eff_start;
  logic              eff_present;
  logic              do_push;
  logic              do_flush;
  logic [KIND_W-1:0] push_kind;
  logic              emit0;
  logic              emit1;
  logic              req_ok;
  result_t           held_res;
  result_t           new_res;
  result_t           blank_res;

  // codes past the body act as a fresh method start
  always_comb begin
    if (phase_q > PH_BODY) begin
      eff_phase   = PH_METHOD;
      eff_start   = 1'b1;
      eff_present = 1'b0;
    end else begin
      eff_phase   = phase_q;
      eff_start   = start_q;
      eff_present = hold_present_q;
    end
  end

  always_comb begin
    phase_d        = eff_phase;
    start_d        = eff_start;
    hold_byte_d    = hold_byte_q;
    hold_kind_d    = hold_kind_q;
    hold_first_d   = hold_first_q;
    hold_present_d = eff_present;
    do_push        = 1'b0;
    do_flush       = 1'b0;
    push_kind      = KIND_METHOD;

    case (eff_phase)
      PH_METHOD, PH_URI: begin
        if (eff_start || byte_i != CHAR_SP) begin
          do_push   = 1'b1;
          push_kind = (eff_phase == PH_METHOD) ? KIND_METHOD : KIND_URI;
        end else begin
          do_flush = 1'b1;
          phase_d  = (eff_phase == PH_METHOD) ? PH_URI : PH_VERSION;
          start_d  = 1'b1;
        end
      end
      PH_VERSION: begin
        if (byte_i == CHAR_LF) begin
          phase_d = PH_NAME;
          start_d = 1'b1;
        end
      end
      PH_NAME: begin
        if (eff_start && byte_i == CHAR_CR) begin
          phase_d = PH_SKIP;
        end else if (!eff_start && byte_i == CHAR_SP) begin
          // held colon is dropped
          hold_present_d = 1'b0;
          phase_d        = PH_VALUE;
          start_d        = 1'b1;
        end else begin
          do_push   = 1'b1;
          push_kind = KIND_NAME;
        end
      end
      PH_VALUE: begin
        if (!eff_start && byte_i == CHAR_LF) begin
          // held CR is dropped
          hold_present_d = 1'b0;
          phase_d        = PH_NAME;
          start_d        = 1'b1;
        end else begin
          do_push   = 1'b1;
          push_kind = KIND_VALUE;
        end
      end
      PH_SKIP: begin
        phase_d = PH_BODY;
        start_d = 1'b1;
      end
      default: begin
        do_push   = 1'b1;
        push_kind = KIND_BODY;
      end
    endcase

    emit0 = eff_present && (do_push || do_flush);
    if (do_flush) begin
      hold_present_d = 1'b0;
    end
    if (do_push) begin
      hold_byte_d    = byte_i;
      hold_kind_d    = push_kind;
      hold_first_d   = eff_start;
      hold_present_d = 1'b1;
      start_d        = 1'b0;
    end

    req_ok = (phase_d >= PH_VERSION);
    emit1  = last_i && (phase_d == PH_BODY) && hold_present_d;

    held_res = '{data: hold_byte_q, byte_valid: 1'b1, kind: hold_kind_q,
                 first: hold_first_q, done: 1'b0, req_valid: 1'b0};
    new_res  = '{data: hold_byte_d, byte_valid: 1'b1, kind: hold_kind_d,
                 first: hold_first_d, done: 1'b0, req_valid: 1'b0};
    blank_res = '0;

    step_o.r1 = new_res;
    if (emit0) begin
      step_o.r0 = held_res;
    end else if (emit1) begin
      step_o.r0 = new_res;
    end else begin
      step_o.r0 = blank_res;
    end
    step_o.cnt = {1'b0, emit0} + {1'b0, emit1};

    if (last_i) begin
      if (step_o.cnt == 2'd2) begin
        step_o.r1.done      = 1'b1;
        step_o.r1.req_valid = req_ok;
      end else begin
        step_o.r0.done      = 1'b1;
        step_o.r0.req_valid = req_ok;
        step_o.cnt          = 2'd1;
      end
      phase_d        = PH_METHOD;
      start_d        = 1'b1;
      hold_byte_d    = '0;
      hold_kind_d    = KIND_METHOD;
      hold_first_d   = 1'b0;
      hold_present_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_METHOD;
      start_q        <= 1'b1;
      hold_byte_q    <= '0;
      hold_kind_q    <= KIND_METHOD;
      hold_first_q   <= 1'b0;
      hold_present_q <= 1'b0;
    end else if (fire_i) begin
      phase_q        <= phase_d;
      start_q        <= start_d;
      hold_byte_q    <= hold_byte_d;
      hold_kind_q    <= hold_kind_d;
      hold_first_q   <= hold_first_d;
      hold_present_q <= hold_present_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/hrfs_outq.sv */
`default_nettype none

module hrfs_outq
  import hrfs_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [1:0] push_cnt_i,
  input  wire result_t    push0_i,
  input  wire result_t    push1_i,
  output logic            has_room_o,
  output logic            valid_o,
  input  wire logic       ready_i,
  output result_t         head_o
);

  result_t           mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic              pop;

  assign valid_o    = (cnt_q != '0);
  assign head_o     = mem_q[rd_ptr_q];
  assign pop        = valid_o && ready_i;
  // room for the two words a final byte may produce
  assign has_room_o = (cnt_q <= QCNT_W'(QDEPTH - 2));
  assign wr_ptr_nxt = wr_ptr_q + QPTR_W'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + QPTR_W'(push_cnt_i);
    rd_ptr_d = pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + QCNT_W'(push_cnt_i) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_nxt] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("result queue count past depth");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_cnt_i != 2'd0 |-> has_room_o)
    else $error("result written without room");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    QPTR_W'(wr_ptr_q - rd_ptr_q) == QPTR_W'(cnt_q))
    else $error("queue pointers disagree with count");

  a_double_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_cnt_i == 2'd2 && !pop) |=> cnt_q == $past(cnt_q) + QCNT_W'(2))
    else $error("double write lost a word");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !ready_i) |=> valid_o)
    else $error("stalled word vanished");

endmodule

`default_nettype wire
